/* hw/rtl/lpf_pkg.sv */
package lpf_pkg;

	localparam int unsigned MAX_LINE_DEF    = 1024;
	localparam int unsigned PATTERN_MAX_DEF = 8;

	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [7:0] NUL_BYTE     = 8'h00;

	// register indexes, byte address = 8 * index
	localparam logic [1:0] REG_PATTERN = 2'd0;
	localparam logic [1:0] REG_LENGTH  = 2'd1;
	localparam logic [1:0] REG_INVERT  = 2'd2;

	typedef struct packed {
		logic [63:0] pattern_bytes;
		logic [3:0]  pattern_length;
		logic        invert_match;
	} lpf_cfg_t;

	// Usable pattern length: clipped to the window depth and cut at the first NUL.
	function automatic logic [3:0] eff_len(input logic [63:0] pat, input logic [3:0] len,
			input int unsigned pmax);
		logic [3:0] n;
		logic [3:0] res;
		logic       done;
		n = len;
		if (32'(n) > pmax) n = 4'(pmax);
		if (n > 4'd8) n = 4'd8;
		res  = n;
		done = 1'b0;
		for (int k = 0; k < 8; k++) begin
			if (!done && 4'(k) < n && pat[8*k +: 8] == NUL_BYTE) begin
				res  = 4'(k);
				done = 1'b1;
			end
		end
		return res;
	endfunction

endpackage

/* hw/rtl/lpf_in_if.sv */
interface lpf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_input;

	modport source (output valid, output text_byte, output end_of_input, input ready);
	modport sink (input valid, input text_byte, input end_of_input, output ready);
endinterface

/* hw/rtl/lpf_res_if.sv */
interface lpf_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] line_number;
	logic [9:0]  line_length;
	logic        pattern_found;
	logic        line_selected;

	modport source (output valid, output line_number, output line_length,
		output pattern_found, output line_selected, input ready);
	modport sink (input valid, input line_number, input line_length,
		input pattern_found, input line_selected, output ready);
endinterface

/* hw/rtl/lpf_cfg_regs.sv */
module lpf_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [63:0]      pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	output lpf_pkg::lpf_cfg_t cfg
);

	logic [63:0] pattern_q;
	logic [3:0]  length_q;
	logic        invert_q;
	logic [1:0]  idx;
	logic        wr;

	assign idx    = paddr[4:3];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= '0;
			invert_q  <= 1'b0;
		end else if (wr) begin
			case (idx)
				lpf_pkg::REG_PATTERN: pattern_q <= pwdata;
				lpf_pkg::REG_LENGTH:  length_q  <= pwdata[3:0];
				lpf_pkg::REG_INVERT:  invert_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			lpf_pkg::REG_PATTERN: prdata = pattern_q;
			lpf_pkg::REG_LENGTH:  prdata = {60'd0, length_q};
			lpf_pkg::REG_INVERT:  prdata = {63'd0, invert_q};
			default:              prdata = '0;
		endcase
	end

	assign cfg.pattern_bytes  = pattern_q;
	assign cfg.pattern_length = length_q;
	assign cfg.invert_match   = invert_q;

endmodule

/* hw/rtl/lpf_matcher.sv */
module lpf_matcher #(
	parameter int unsigned MAX_LINE    = lpf_pkg::MAX_LINE_DEF,
	parameter int unsigned PATTERN_MAX = lpf_pkg::PATTERN_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lpf_pkg::lpf_cfg_t cfg,
	input  logic              in_valid,
	input  logic [7:0]        text_byte,
	input  logic              end_of_input,
	output logic              step,
	lpf_res_if.source         res
);

	localparam int unsigned LW = $clog2(MAX_LINE);
	localparam int unsigned SW = $clog2(PATTERN_MAX + 1);

	logic [7:0]    win_q [PATTERN_MAX];
	logic [7:0]    win_n [PATTERN_MAX];
	logic [LW-1:0] bytes_q, bytes_n;
	logic [SW-1:0] searched_q, searched_n;
	logic          hit_q, hit_n;
	logic          stopped_q, stopped_n;
	logic [31:0]   lines_q, lines_n;
	logic          finish;
	logic          found;
	logic          sel_hit;
	logic          ok;
	logic [3:0]    plen;
	logic [31:0]   len_ext;

	logic          out_v_q;
	logic [31:0]   num_q;
	logic [9:0]    len_q;
	logic          found_q;
	logic          selected_q;

	assign plen = lpf_pkg::eff_len(cfg.pattern_bytes, cfg.pattern_length, PATTERN_MAX);
	// only a line end needs room in the result register
	assign step = in_valid && (!out_v_q || res.ready || !finish);

	always_comb begin
		win_n      = win_q;
		bytes_n    = bytes_q;
		searched_n = searched_q;
		hit_n      = hit_q;
		stopped_n  = stopped_q;
		finish     = 1'b0;
		sel_hit    = 1'b0;
		ok         = 1'b1;
		if (end_of_input) begin
			finish = bytes_q != '0;
		end else begin
			if (!stopped_q) begin
				if (text_byte == lpf_pkg::NUL_BYTE) begin
					stopped_n = 1'b1;
				end else begin
					win_n[0] = text_byte;
					for (int k = 1; k < PATTERN_MAX; k++) win_n[k] = win_q[k-1];
					if (32'(searched_q) < PATTERN_MAX) searched_n = searched_q + 1'b1;
					// all pattern lengths compared at once, the live one picked after
					for (int l = 1; l <= PATTERN_MAX; l++) begin
						ok = 1'b1;
						for (int k = 0; k < l; k++) begin
							if (win_n[l-1-k] != cfg.pattern_bytes[8*k +: 8]) ok = 1'b0;
						end
						if (plen == 4'(l)) sel_hit = ok;
					end
					if (plen != 4'd0 && 4'(searched_n) >= plen && sel_hit) hit_n = 1'b1;
				end
			end
			bytes_n = bytes_q + 1'b1;
			finish  = text_byte == lpf_pkg::NEWLINE_BYTE || bytes_n >= LW'(MAX_LINE - 1);
		end
	end

	assign found   = hit_n || plen == 4'd0;
	assign lines_n = (lines_q == 32'hFFFF_FFFF) ? lines_q : lines_q + 32'd1;
	assign len_ext = 32'(bytes_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PATTERN_MAX; k++) win_q[k] <= '0;
			bytes_q    <= '0;
			searched_q <= '0;
			hit_q      <= 1'b0;
			stopped_q  <= 1'b0;
			lines_q    <= '0;
		end else if (step) begin
			if (finish || end_of_input) begin
				for (int k = 0; k < PATTERN_MAX; k++) win_q[k] <= '0;
				bytes_q    <= '0;
				searched_q <= '0;
				hit_q      <= 1'b0;
				stopped_q  <= 1'b0;
			end else begin
				win_q      <= win_n;
				bytes_q    <= bytes_n;
				searched_q <= searched_n;
				hit_q      <= hit_n;
				stopped_q  <= stopped_n;
			end
			if (finish) lines_q <= lines_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (step && finish) begin
			out_v_q <= 1'b1;
		end else if (res.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && finish) begin
			num_q      <= lines_n;
			len_q      <= len_ext[9:0];
			found_q    <= found;
			selected_q <= found ^ cfg.invert_match;
		end
	end

	assign res.valid         = out_v_q;
	assign res.line_number   = num_q;
	assign res.line_length   = len_q;
	assign res.pattern_found = found_q;
	assign res.line_selected = selected_q;

endmodule

/* hw/rtl/line_pattern_filter_top.sv */
// channel     dir  beat contents
// text_in     in   text_byte[7:0], end_of_input
// lines_out   out  line_number[31:0], line_length[9:0], pattern_found, line_selected
// apb         in   pattern (0x00), length (0x08), invert (0x10), 64-bit data
//
// One byte per clock sustained. A byte is registered in the input register at
// accept; the window compare and line bookkeeping then run from that register
// into the result register, which loads a line's result once it has room.
// text_in stays ready while a result waits, unless a line end meets a full
// result register. Reset clears line state and the line counter; no sweep.
module line_pattern_filter_top #(
	parameter int unsigned MAX_LINE    = lpf_pkg::MAX_LINE_DEF,
	parameter int unsigned PATTERN_MAX = lpf_pkg::PATTERN_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	lpf_in_if.sink      text_in,
	lpf_res_if.source   lines_out
);

	lpf_pkg::lpf_cfg_t cfg;
	logic              v_s1;
	logic [7:0]        byte_s1;
	logic              eoi_s1;
	logic              adv;

	lpf_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign text_in.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (text_in.ready) begin
			v_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid) begin
			byte_s1 <= text_in.text_byte;
			eoi_s1  <= text_in.end_of_input;
		end
	end

	lpf_matcher #(
		.MAX_LINE    (MAX_LINE),
		.PATTERN_MAX (PATTERN_MAX)
	) u_match (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (v_s1),
		.text_byte    (byte_s1),
		.end_of_input (eoi_s1),
		.step         (adv),
		.res          (lines_out)
	);

	a_num_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lines_out.valid |-> lines_out.line_number != 32'd0)
		else $error("result with zero line number");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(byte_s1) && $stable(eoi_s1))
		else $error("stalled input register lost its byte");

	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		lines_out.valid && lines_out.ready && !adv |=> !lines_out.valid)
		else $error("taken result shown again");

endmodule
